// ----- hw/rtl/mpool_pkg.sv -----
// Shared constants and types for the 2x2 max pooling block.
package mpool_pkg;

	// Default sizes
	localparam int MAX_WIDTH_DEF = 256;
	localparam int DATA_BITS_DEF = 16;

	// Fixed field widths
	localparam int CFG_W  = 9;
	localparam int MASK_W = 4;

	// Input word modes
	localparam logic MODE_FWD = 1'b0;
	localparam logic MODE_BWD = 1'b1;

	// Result word kinds
	localparam logic KIND_POOL = 1'b0;
	localparam logic KIND_GRAD = 1'b1;

	// Window mask bit positions
	localparam int BIT_TL = 0;
	localparam int BIT_TR = 1;
	localparam int BIT_BL = 2;
	localparam int BIT_BR = 3;

	// Output queue depth and its count width
	localparam int QDEPTH = 2;
	localparam int QCNT_W = 2;

	// Control that travels with a result word into the output queue
	typedef struct packed {
		logic              push;
		logic              kind;
		logic [MASK_W-1:0] mask;
	} res_ctl_t;

	// Output queue status seen by the window stage
	typedef struct packed {
		logic              full;
		logic [QCNT_W-1:0] count;
	} queue_stat_t;

endpackage

// ----- hw/rtl/mpool_line_mem.sv -----
// Single-port line memory: one pair of even-row pixels per entry.
module mpool_line_mem #(
	parameter int DEPTH  = 128,
	parameter int AW     = 7,
	parameter int WORD_W = 32
) (
	input  logic              clk,
	input  logic              en,
	input  logic              we,
	input  logic [AW-1:0]     addr,
	input  logic [WORD_W-1:0] wr_data,
	output logic [WORD_W-1:0] rd_data
);
	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	// Write a pair, or read one into the output register
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wr_data;
			end else begin
				rd_data_q <= mem_q[addr];
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hw/rtl/mpool_window.sv -----
// Window stage: holds one word, takes the max and argmax mask or passes a gradient.
module mpool_window #(
	parameter int DATA_BITS = mpool_pkg::DATA_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic                        kind,
	input  logic signed [DATA_BITS-1:0] a_val,
	input  logic signed [DATA_BITS-1:0] bl_val,
	input  logic [mpool_pkg::MASK_W-1:0] mask,
	input  logic [2*DATA_BITS-1:0]      rd_data,
	input  mpool_pkg::queue_stat_t      qstat,
	output logic                        busy,
	output logic                        valid,
	output mpool_pkg::res_ctl_t         res,
	output logic signed [DATA_BITS-1:0] res_value
);
	import mpool_pkg::*;

	logic                        valid_s1;
	logic                        kind_s1;
	logic signed [DATA_BITS-1:0] a_s1;
	logic signed [DATA_BITS-1:0] bl_s1;
	logic [MASK_W-1:0]           mask_s1;

	logic signed [DATA_BITS-1:0] tl;
	logic signed [DATA_BITS-1:0] tr;
	logic signed [DATA_BITS-1:0] max_top;
	logic signed [DATA_BITS-1:0] max_bot;
	logic signed [DATA_BITS-1:0] max_all;
	logic [MASK_W-1:0]           win_mask;

	// Hold the word while the output queue is full
	assign busy  = valid_s1 && qstat.full;
	assign valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!busy) begin
			valid_s1 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_s1 <= kind;
			a_s1    <= a_val;
			bl_s1   <= bl_val;
			mask_s1 <= mask;
		end
	end

	// Top pair comes from the line memory, low half is the left column
	assign tl = signed'(rd_data[DATA_BITS-1:0]);
	assign tr = signed'(rd_data[2*DATA_BITS-1:DATA_BITS]);

	// Reduce the window in two levels
	always_comb begin
		max_top = (tl >= tr) ? tl : tr;
		max_bot = (bl_s1 >= a_s1) ? bl_s1 : a_s1;
		max_all = (max_top >= max_bot) ? max_top : max_bot;
		win_mask = '0;
		win_mask[BIT_TL] = (tl == max_all);
		win_mask[BIT_TR] = (tr == max_all);
		win_mask[BIT_BL] = (bl_s1 == max_all);
		win_mask[BIT_BR] = (a_s1 == max_all);
	end

	// Hand the result word to the output queue
	always_comb begin
		res.push = valid_s1 && !qstat.full;
		res.kind = kind_s1;
		if (kind_s1 == KIND_GRAD) begin
			res.mask  = mask_s1;
			res_value = a_s1;
		end else begin
			res.mask  = win_mask;
			res_value = max_all;
		end
	end

endmodule

// ----- hw/rtl/mpool_out_queue.sv -----
// Two-entry output queue that parts the result side from the window stage.
module mpool_out_queue #(
	parameter int DATA_BITS = mpool_pkg::DATA_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mpool_pkg::res_ctl_t          res,
	input  logic signed [DATA_BITS-1:0]  res_value,
	output mpool_pkg::queue_stat_t       qstat,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         result_kind,
	output logic signed [DATA_BITS-1:0]  pooled_value,
	output logic [mpool_pkg::MASK_W-1:0] mask_out,
	output logic signed [DATA_BITS-1:0]  grad_top_left,
	output logic signed [DATA_BITS-1:0]  grad_top_right,
	output logic signed [DATA_BITS-1:0]  grad_bottom_left,
	output logic signed [DATA_BITS-1:0]  grad_bottom_right
);
	import mpool_pkg::*;

	logic                        kind_q  [QDEPTH];
	logic [MASK_W-1:0]           mask_q  [QDEPTH];
	logic signed [DATA_BITS-1:0] value_q [QDEPTH];
	logic                        wr_ptr_q;
	logic                        rd_ptr_q;
	logic [QCNT_W-1:0]           cnt_q;
	logic                        pop;

	logic                        head_kind;
	logic [MASK_W-1:0]           head_mask;
	logic signed [DATA_BITS-1:0] head_value;

	assign out_valid   = (cnt_q != '0);
	assign pop         = out_valid && !out_stall;
	assign qstat.full  = (cnt_q == QCNT_W'(QDEPTH));
	assign qstat.count = cnt_q;

	// Store the incoming word
	always_ff @(posedge clk) begin
		if (res.push) begin
			kind_q[wr_ptr_q]  <= res.kind;
			mask_q[wr_ptr_q]  <= res.mask;
			value_q[wr_ptr_q] <= res_value;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (res.push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (res.push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !res.push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	// Expand the head word into the result fields
	assign head_kind  = kind_q[rd_ptr_q];
	assign head_mask  = mask_q[rd_ptr_q];
	assign head_value = value_q[rd_ptr_q];

	always_comb begin
		result_kind       = head_kind;
		mask_out          = head_mask;
		pooled_value      = (head_kind == KIND_POOL) ? head_value : '0;
		grad_top_left     = (head_kind == KIND_GRAD && head_mask[BIT_TL]) ? head_value : '0;
		grad_top_right    = (head_kind == KIND_GRAD && head_mask[BIT_TR]) ? head_value : '0;
		grad_bottom_left  = (head_kind == KIND_GRAD && head_mask[BIT_BL]) ? head_value : '0;
		grad_bottom_right = (head_kind == KIND_GRAD && head_mask[BIT_BR]) ? head_value : '0;
	end

endmodule

// ----- hw/rtl/max_pool_2x2_with_mask.sv -----
// A result word passes the window stage register and then an output queue entry.
// Throughput: one input word per cycle, forward or backprop, sustained while results drain.
// The single-port line memory serves one access per pixel pair. A two-entry output queue
// keeps input going while a result waits; input stalls only when queue and window are full.
// Reset clears stream position and queue, and sets the row width to 2; the line memory
// is left as it is and needs no clearing pass.
module max_pool_2x2_with_mask #(
	parameter int MAX_WIDTH = mpool_pkg::MAX_WIDTH_DEF,
	parameter int DATA_BITS = mpool_pkg::DATA_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [mpool_pkg::CFG_W-1:0]  cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         mode,
	input  logic signed [DATA_BITS-1:0]  pixel_value,
	input  logic signed [DATA_BITS-1:0]  pooled_gradient,
	input  logic [mpool_pkg::MASK_W-1:0] mask_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         result_kind,
	output logic signed [DATA_BITS-1:0]  pooled_value,
	output logic [mpool_pkg::MASK_W-1:0] mask_out,
	output logic signed [DATA_BITS-1:0]  grad_top_left,
	output logic signed [DATA_BITS-1:0]  grad_top_right,
	output logic signed [DATA_BITS-1:0]  grad_bottom_left,
	output logic signed [DATA_BITS-1:0]  grad_bottom_right
);
	import mpool_pkg::*;

	localparam int PAIRS = MAX_WIDTH / 2;
	localparam int AW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;

	// Last pair index of a row for a given width register value
	function automatic logic [AW-1:0] last_pair_of(input logic [CFG_W-1:0] w);
		int pw;
		pw = int'(w[CFG_W-1:1]);
		if (pw < 1) pw = 1;
		if (pw > PAIRS) pw = PAIRS;
		return AW'(pw - 1);
	endfunction

	logic [AW-1:0]               last_pair_q;
	logic [AW-1:0]               pair_q;
	logic                        half_q;
	logic                        row_odd_q;
	logic signed [DATA_BITS-1:0] hold_q;
	logic signed [DATA_BITS-1:0] left_q;

	logic                        accept;
	logic                        fwd;
	logic                        produce;
	logic                        mem_en;
	logic                        mem_we;
	logic [2*DATA_BITS-1:0]      rd_data;
	logic                        win_busy;
	logic                        win_valid;
	res_ctl_t                    res;
	logic signed [DATA_BITS-1:0] res_value;
	queue_stat_t                 qstat;

	assign in_stall = win_busy;
	assign accept   = in_valid && !in_stall;
	assign fwd      = accept && (mode == MODE_FWD);
	assign produce  = (mode == MODE_BWD) || (row_odd_q && half_q);

	// Even row writes a pair on its odd column, odd row reads it back there
	assign mem_en = fwd && half_q;
	assign mem_we = !row_odd_q;

	// Width register and stream position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pair_q <= '0;
			pair_q      <= '0;
			half_q      <= 1'b0;
			row_odd_q   <= 1'b0;
		end else if (cfg_wr_en) begin
			last_pair_q <= last_pair_of(cfg_wr_data);
			pair_q      <= '0;
			half_q      <= 1'b0;
			row_odd_q   <= 1'b0;
		end else if (fwd) begin
			half_q <= !half_q;
			if (half_q) begin
				if (pair_q == last_pair_q) begin
					pair_q    <= '0;
					row_odd_q <= !row_odd_q;
				end else begin
					pair_q <= pair_q + AW'(1);
				end
			end
		end
	end

	// Hold the left pixel of each pair
	always_ff @(posedge clk) begin
		if (fwd && !half_q) begin
			if (row_odd_q) begin
				left_q <= pixel_value;
			end else begin
				hold_q <= pixel_value;
			end
		end
	end

	mpool_line_mem #(
		.DEPTH  (PAIRS),
		.AW     (AW),
		.WORD_W (2 * DATA_BITS)
	) u_line_mem (
		.clk     (clk),
		.en      (mem_en),
		.we      (mem_we),
		.addr    (pair_q),
		.wr_data ({pixel_value, hold_q}),
		.rd_data (rd_data)
	);

	mpool_window #(
		.DATA_BITS (DATA_BITS)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept && produce),
		.kind      ((mode == MODE_BWD) ? KIND_GRAD : KIND_POOL),
		.a_val     ((mode == MODE_BWD) ? pooled_gradient : pixel_value),
		.bl_val    (left_q),
		.mask      (mask_in),
		.rd_data   (rd_data),
		.qstat     (qstat),
		.busy      (win_busy),
		.valid     (win_valid),
		.res       (res),
		.res_value (res_value)
	);

	mpool_out_queue #(
		.DATA_BITS (DATA_BITS)
	) u_out_queue (
		.clk               (clk),
		.arst_n            (arst_n),
		.res               (res),
		.res_value         (res_value),
		.qstat             (qstat),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.result_kind       (result_kind),
		.pooled_value      (pooled_value),
		.mask_out          (mask_out),
		.grad_top_left     (grad_top_left),
		.grad_top_right    (grad_top_right),
		.grad_bottom_left  (grad_bottom_left),
		.grad_bottom_right (grad_bottom_right)
	);

`ifndef SYNTHESIS
	// Queue never overfills
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= QCNT_W'(QDEPTH))
		else $error("output queue count beyond depth");

	// Input stalls only behind a held window word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (win_valid && qstat.full))
		else $error("input stalled without a held word");

	// Line memory reads happen only where a window closes
	a_read_place: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_en && !mem_we) |-> (row_odd_q && half_q && win_busy == 1'b0))
		else $error("line memory read outside a closing pixel");

	// A width write restarts the stream
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |=> (pair_q == '0 && !half_q && !row_odd_q))
		else $error("stream position not cleared by width write");
`endif

endmodule
